### sv/asu_pkg.sv
// shared types and constants of the advection stencil update block
`timescale 1ns / 1ps

package asu_pkg;

  localparam int DATA_W   = 32;
  localparam int RATIO_W  = 20;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W   = DATA_W + 1;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int SAT_W    = 40;
  localparam int Q_W      = SAT_W + RATIO_W + 1;
  localparam int RND_W    = Q_W + 1;
  localparam int V_W      = 64;

  localparam logic [RATIO_W-1:0] STEP_RATIO_RST = RATIO_W'(2621);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_RATIO  = 2'd0,
    REG_SCHEME_MODE = 2'd1
  } reg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_UPWIND   = 2'd0,
    MODE_CENTERED = 2'd1,
    MODE_SOURCE   = 2'd2
  } scheme_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_SCALE,
    ST_WRITE
  } asu_state_e;

  typedef enum logic [1:0] {
    OP_FIRST,
    OP_LAST_IN,
    OP_LAST_WIN
  } op_sel_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] velocity;
    logic signed [DATA_W-1:0] source_term;
    logic                     first_point;
    logic                     last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_value;
    logic                     row_end;
  } out_item_t;

  typedef struct packed {
    logic    win_update;
    logic    load_op;
    op_sel_e op_sel;
    logic    diff_en;
    logic    mul_en;
    logic    scale_en;
    logic    out_load;
  } asu_cmd_t;

  typedef struct packed {
    logic need_first;
    logic is_last;
    logic out_free;
  } asu_stat_t;

endpackage

### sv/asu_if.sv
// valid/ready channel interfaces for input points and results
`timescale 1ns / 1ps

interface asu_in_if
  import asu_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asu_out_if
  import asu_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/asu_ctrl.sv
// controller state machine sequencing the stencil passes of one point
`timescale 1ns / 1ps

module asu_ctrl
  import asu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  asu_stat_t stat_i,
  output asu_cmd_t  cmd_o
);

  asu_state_e state_q, state_d;
  logic       pend2_q, pend2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend2_q <= pend2_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pend2_d    = pend2_q;
    in_ready_o = 1'b0;
    cmd_o      = '{win_update: 1'b0, load_op: 1'b0, op_sel: OP_FIRST,
                   diff_en: 1'b0, mul_en: 1'b0, scale_en: 1'b0, out_load: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.win_update = 1'b1;
          if (stat_i.need_first) begin
            // pending centre finishes now, row end pass follows if marked
            cmd_o.load_op = 1'b1;
            cmd_o.op_sel  = OP_FIRST;
            pend2_d       = stat_i.is_last;
            state_d       = ST_DIFF;
          end else if (stat_i.is_last) begin
            cmd_o.load_op = 1'b1;
            cmd_o.op_sel  = OP_LAST_IN;
            pend2_d       = 1'b0;
            state_d       = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale_en = 1'b1;
        state_d        = ST_WRITE;
      end
      ST_WRITE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (pend2_q) begin
            // row end pass takes its operands from the updated window
            cmd_o.load_op = 1'b1;
            cmd_o.op_sel  = OP_LAST_WIN;
            pend2_d       = 1'b0;
            state_d       = ST_DIFF;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/asu_dpath.sv
// datapath: config registers, point window, difference and scaling stages, result register
`timescale 1ns / 1ps

module asu_dpath
  import asu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RATIO_W-1:0]   cfg_wdata_i,
  input  in_item_t             in_data_i,
  input  asu_cmd_t             cmd_i,
  output asu_stat_t            stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  localparam logic signed [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [SAT_W-1:0]  MAX40 = {1'b0, {(SAT_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0]  MIN40 = {1'b1, {(SAT_W-1){1'b0}}};
  localparam logic signed [RND_W-1:0]  HALF_UP   = RND_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0]  HALF_CENT = RND_W'(1) << FRAC_BITS;

  // configuration
  logic [RATIO_W-1:0] ratio_q;
  logic [MODE_W-1:0]  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= STEP_RATIO_RST;
      mode_q  <= MODE_UPWIND;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEP_RATIO:  ratio_q <= cfg_wdata_i;
        REG_SCHEME_MODE: mode_q  <= cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic centered, add_src;
  assign centered = (mode_q == MODE_CENTERED);
  assign add_src  = (mode_q == MODE_SOURCE);

  // point window
  logic signed [DATA_W-1:0] left_q, center_q, cvel_q, csrc_q;
  logic                     fill_q;
  logic                     new_row;
  logic signed [DATA_W-1:0] left_next;

  assign new_row   = in_data_i.first_point || !fill_q;
  assign left_next = new_row ? in_data_i.sample : center_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      center_q <= '0;
      cvel_q   <= '0;
      csrc_q   <= '0;
      fill_q   <= 1'b0;
    end else if (cmd_i.win_update) begin
      left_q   <= left_next;
      center_q <= in_data_i.sample;
      cvel_q   <= in_data_i.velocity;
      csrc_q   <= in_data_i.source_term;
      fill_q   <= !in_data_i.last_point;
    end
  end

  // operands of the current pass
  logic signed [DATA_W-1:0] op_l_q, op_c_q, op_r_q, op_a_q, op_s_q;
  logic                     op_end_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      case (cmd_i.op_sel)
        OP_FIRST: begin
          op_l_q   <= left_q;
          op_c_q   <= center_q;
          op_r_q   <= in_data_i.sample;
          op_a_q   <= cvel_q;
          op_s_q   <= csrc_q;
          op_end_q <= 1'b0;
        end
        OP_LAST_IN: begin
          op_l_q   <= left_next;
          op_c_q   <= in_data_i.sample;
          op_r_q   <= in_data_i.sample;
          op_a_q   <= in_data_i.velocity;
          op_s_q   <= in_data_i.source_term;
          op_end_q <= 1'b1;
        end
        default: begin
          // ghost point on the right equals the centre
          op_l_q   <= left_q;
          op_c_q   <= center_q;
          op_r_q   <= center_q;
          op_a_q   <= cvel_q;
          op_s_q   <= csrc_q;
          op_end_q <= 1'b1;
        end
      endcase
    end
  end

  // stage 1: saturated difference
  logic signed [DIFF_W-1:0] diff_full;
  logic signed [DATA_W-1:0] d_q;

  always_comb begin
    if (centered) begin
      diff_full = DIFF_W'(op_r_q) - DIFF_W'(op_l_q);
    end else if (!op_a_q[DATA_W-1]) begin
      diff_full = DIFF_W'(op_c_q) - DIFF_W'(op_l_q);
    end else begin
      diff_full = DIFF_W'(op_r_q) - DIFF_W'(op_c_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      if (diff_full[DIFF_W-1] != diff_full[DIFF_W-2]) begin
        d_q <= diff_full[DIFF_W-1] ? MIN32 : MAX32;
      end else begin
        d_q <= diff_full[DATA_W-1:0];
      end
    end
  end

  // stage 2: velocity times difference
  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(op_a_q) * PROD_W'(d_q);
    end
  end

  // stage 3: floor shift, 40 bit saturation, scale by step ratio
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [SAT_W-1:0]  p_sat;
  logic signed [Q_W-1:0]    q_q;

  assign prod_sh = prod_q >>> FRAC_BITS;

  always_comb begin
    if (prod_sh[PROD_W-1:SAT_W-1] != {(PROD_W-SAT_W+1){prod_sh[PROD_W-1]}}) begin
      p_sat = prod_sh[PROD_W-1] ? MIN40 : MAX40;
    end else begin
      p_sat = prod_sh[SAT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      q_q <= Q_W'(p_sat) * $signed({1'b0, ratio_q});
    end
  end

  // final: round to nearest, subtract from centre, add source in source mode, saturate
  logic signed [RND_W-1:0]  q_ext, t_val;
  logic signed [V_W-1:0]    v_full;
  logic signed [DATA_W-1:0] v_sat;

  assign q_ext = RND_W'(q_q);

  always_comb begin
    if (centered) begin
      t_val = (q_ext + HALF_CENT) >>> (FRAC_BITS + 1);
    end else begin
      t_val = (q_ext + HALF_UP) >>> FRAC_BITS;
    end
    v_full = V_W'(op_c_q) - V_W'(t_val);
    if (add_src) begin
      v_full = v_full + V_W'(op_s_q);
    end
    if (v_full[V_W-1:DATA_W-1] != {(V_W-DATA_W+1){v_full[V_W-1]}}) begin
      v_sat = v_full[V_W-1] ? MIN32 : MAX32;
    end else begin
      v_sat = v_full[DATA_W-1:0];
    end
  end

  // result register
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.new_value <= v_sat;
      out_data_q.row_end   <= op_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign stat_o.need_first = fill_q && !in_data_i.first_point;
  assign stat_o.is_last    = in_data_i.last_point;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### sv/advection_stencil_update.sv
// top level of the one-dimensional advection stencil update block
`timescale 1ns / 1ps

// Grid points of a row arrive left to right on in_i; each result on out_o is the next
// time level value of one point, given once its right neighbour is in (or at once for the
// point marked last, whose right ghost is itself). A point completes none, one or two results;
// each passes in order through the shared datapath (difference, velocity multiply, ratio
// multiply, round and saturate) and waits while the result register still holds an untaken
// transaction. Input is taken while a finished result waits. The user must write step_ratio
// and scheme_mode through cfg_we_i only while the block is idle; the block itself does not
// enforce this.
module advection_stencil_update
  import asu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RATIO_W-1:0]   cfg_wdata_i,
  asu_in_if.sink               in_i,
  asu_out_if.source            out_o
);

  asu_cmd_t  cmd;
  asu_stat_t stat;

  asu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  asu_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule
